// File: rtl/core/endpoint_id_allocator_top_defines.svh
// assertion macros shared by the endpoint id allocator rtl
// depends on nothing; users must have clk and arst_n in scope
`ifndef ENDPOINT_ID_ALLOCATOR_TOP_DEFINES_SVH
`define ENDPOINT_ID_ALLOCATOR_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define EPID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EPID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/epid_pkg.sv
// types and constants of the endpoint id allocator
// depends on nothing
`timescale 1ns / 1ps

package epid_pkg;

	localparam int ID_W = 16;

	// operation codes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// status codes
	localparam logic [1:0] ST_GRANTED    = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
	localparam logic [1:0] ST_RELEASED   = 2'd2;
	localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

	// register indexes
	localparam logic CFG_RANGE_FIRST = 1'b0;
	localparam logic CFG_RANGE_END   = 1'b1;

	// range used when range_end is zero
	localparam logic [ID_W-1:0] DEFAULT_FIRST = 16'd1;
	localparam logic [ID_W-1:0] DEFAULT_END   = 16'd65534;

	typedef struct packed {
		logic            operation;
		logic [ID_W-1:0] release_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] granted_id;
	} out_item_t;

endpackage

// File: rtl/core/endpoint_id_allocator_top.sv
// Endpoint id allocator: lowest-free id allocation over an in-use bitmap.
// Input channel in_valid/in_ready/in_data carries an operation: allocate
// the lowest free id of the active range, or release in_data.release_id.
// Output channel out_valid/out_ready/out_data returns one result per item:
// status and, when granted, the id. Config port cfg_we/cfg_index/cfg_wdata
// writes range_first (index 0) and range_end (index 1); write only when idle.
// The bitmap sits in a MAP_WORDS x WORD_BITS ram with a registered read.
// Steps from the input transfer to out_valid: the split of the id into word
// and bit (reciprocal multiply), a read state, an evaluate state per bitmap
// word, then the output register. A release reads and evaluates one word; an
// id with no bit in the map skips the read and evaluate states. An allocate
// scans words from the word of the range start (at most MAP_WORDS words); an
// allocate on an empty range goes straight to the finish state. One item is in
// work at a time; the next is taken the cycle after its result enters the
// output register, even while the receiver stalls it there; a new result
// waits while that register is still full.
// After reset a clearing pass writes zeros to every bitmap word, one per
// cycle; no item is taken until it ends.
// Depends on epid_pkg, epid_ram, epid_div and the assertion macro header.
`timescale 1ns / 1ps

`include "endpoint_id_allocator_top_defines.svh"

module endpoint_id_allocator_top #(
	parameter int MAP_WORDS = 2048,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  epid_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output epid_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata
);

	import epid_pkg::*;

	localparam int WA = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int XW = ID_W + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_EVAL,
		S_FIN
	} state_t;

	state_t          state_q;
	logic [WA-1:0]   clr_q;
	logic            op_q;
	logic [XW-1:0]   lo_q;
	logic [XW-1:0]   hi_q;
	logic [WA-1:0]   w_q;
	logic [XW-1:0]   base_q;
	logic [BW-1:0]   bit_q;
	logic            first_q;
	out_item_t       res_q;
	logic            out_valid_q;
	out_item_t       out_data_q;
	logic [ID_W-1:0] range_first_q;
	logic [ID_W-1:0] range_end_q;

	logic            in_xfer;
	logic [ID_W-1:0] eff_lo;
	logic [ID_W-1:0] eff_hi;
	logic            range_empty;

	logic                 div_start;
	logic [ID_W-1:0]      div_dividend;
	logic                 div_done;
	logic [ID_W-1:0]      div_quot;
	logic [BW-1:0]        div_rem;

	logic                 ram_we;
	logic [WA-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WA-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [WORD_BITS-1:0] free_v;
	logic [WORD_BITS-1:0] hit_mask;
	logic                 found;
	logic [BW-1:0]        idx;
	logic [XW-1:0]        lim;
	logic [XW-1:0]        next_base;
	logic                 scan_end;
	logic                 bit_set;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= '0;
			range_end_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_FIRST: range_first_q <= cfg_wdata;
				CFG_RANGE_END:   range_end_q   <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// active range
	assign eff_lo      = (range_end_q == '0) ? DEFAULT_FIRST : range_first_q;
	assign eff_hi      = (range_end_q == '0) ? DEFAULT_END : range_end_q;
	assign range_empty = (eff_lo >= eff_hi);

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// split the id into word and bit
	assign div_start    = in_xfer && !((in_data.operation == OP_ALLOC) && range_empty);
	assign div_dividend = (in_data.operation == OP_RELEASE) ? in_data.release_id : eff_lo;

	epid_div #(
		.DIVISOR (WORD_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// free bits of the word under evaluation inside the active range
	always_comb begin
		lim       = hi_q - base_q;
		next_base = base_q + XW'(WORD_BITS);
		scan_end  = (w_q == WA'(MAP_WORDS - 1)) || (next_base >= hi_q);
		bit_set   = ram_rdata[bit_q];
		for (int j = 0; j < WORD_BITS; j++) begin
			free_v[j] = !ram_rdata[j] && (!first_q || (BW'(j) >= bit_q)) &&
				(XW'(j) < lim);
		end
		found = |free_v;
		idx   = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (free_v[j]) begin
				idx = BW'(j);
			end
		end
		hit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << (op_q == OP_RELEASE ? bit_q : idx);
	end

	// bitmap memory access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = w_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_READ: begin
				ram_re = 1'b1;
			end
			S_EVAL: begin
				if (op_q == OP_RELEASE) begin
					ram_we    = bit_set;
					ram_wdata = ram_rdata & ~hit_mask;
				end else if (found) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | hit_mask;
				end else if (!scan_end) begin
					ram_re    = 1'b1;
					ram_raddr = w_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	epid_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			op_q        <= OP_ALLOC;
			lo_q        <= '0;
			hi_q        <= '0;
			w_q         <= '0;
			base_q      <= '0;
			bit_q       <= '0;
			first_q     <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// output register: filled from the finish state, emptied by a transfer
			if ((state_q == S_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WA'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						op_q <= in_data.operation;
						lo_q <= {1'b0, eff_lo};
						hi_q <= {1'b0, eff_hi};
						if ((in_data.operation == OP_ALLOC) && range_empty) begin
							res_q   <= '{status: ST_EXHAUSTED, granted_id: '0};
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_quot >= ID_W'(MAP_WORDS)) begin
							res_q.status     <= (op_q == OP_RELEASE) ?
								ST_NOT_IN_USE : ST_EXHAUSTED;
							res_q.granted_id <= '0;
							state_q          <= S_FIN;
						end else begin
							w_q     <= div_quot[WA-1:0];
							bit_q   <= div_rem;
							base_q  <= lo_q - XW'(div_rem);
							first_q <= 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (op_q == OP_RELEASE) begin
						res_q.status     <= bit_set ? ST_RELEASED : ST_NOT_IN_USE;
						res_q.granted_id <= '0;
						state_q          <= S_FIN;
					end else if (found) begin
						res_q.status     <= ST_GRANTED;
						res_q.granted_id <= ID_W'(base_q + XW'(idx));
						state_q          <= S_FIN;
					end else if (scan_end) begin
						res_q.status     <= ST_EXHAUSTED;
						res_q.granted_id <= '0;
						state_q          <= S_FIN;
					end else begin
						w_q     <= w_q + 1'b1;
						base_q  <= next_base;
						first_q <= 1'b0;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_data_q <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks on the sequencer and the bitmap port use
	`EPID_ASSERT_NOW(a_no_rw_same_word, ram_we && ram_re, ram_waddr != ram_raddr,
		"bitmap read and write hit the same word")
	`EPID_ASSERT_NEXT(a_one_item_in_work, in_xfer, !in_ready,
		"second item taken while one is in work")
	`EPID_ASSERT_NOW(a_div_done_in_div, div_done, state_q == S_DIV,
		"divider finished outside the split phase")
	`EPID_ASSERT_NOW(a_id_zero_unless_granted,
		out_valid_q && (out_data_q.status != ST_GRANTED), out_data_q.granted_id == '0,
		"nonzero id on a result that is not a grant")

endmodule

// File: rtl/core/epid_ram.sv
// generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module epid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/epid_div.sv
// split of an id by a constant word size through a reciprocal multiply
// depends on epid_pkg
`timescale 1ns / 1ps

module epid_div #(
	parameter int DIVISOR = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [epid_pkg::ID_W-1:0]       dividend,
	output logic                            done,
	output logic [epid_pkg::ID_W-1:0]       quotient,
	output logic [$clog2(DIVISOR)-1:0]      remainder
);

	import epid_pkg::*;

	localparam int RW = $clog2(DIVISOR);
	// shift and rounded-up reciprocal exact for every dividend of ID_W bits
	localparam int SH = ID_W + RW;
	localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) /
		64'(DIVISOR);
	localparam int MW = ID_W + 2;
	localparam int PW = ID_W + MW;

	logic [PW-1:0]   prod;
	logic [ID_W-1:0] back_prod;
	logic [ID_W-1:0] rem_full;
	logic            busy_s1;
	logic [ID_W-1:0] num_s1;
	logic [ID_W-1:0] quot_s1;
	logic            done_q;
	logic [ID_W-1:0] quot_q;
	logic [RW-1:0]   rem_q;

	// quotient by multiply and shift, remainder by multiply back and subtract
	assign prod      = PW'(dividend) * PW'(MW'(RECIP));
	assign back_prod = ID_W'(quot_s1 * ID_W'(DIVISOR));
	assign rem_full  = num_s1 - back_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			num_s1  <= '0;
			quot_s1 <= '0;
			done_q  <= 1'b0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else begin
			busy_s1 <= start;
			done_q  <= busy_s1;
			if (start) begin
				num_s1  <= dividend;
				quot_s1 <= ID_W'(prod >> SH);
			end
			if (busy_s1) begin
				quot_q <= quot_s1;
				rem_q  <= RW'(rem_full);
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

// File: tb/endpoint_id_checker.sv
// result checker for the endpoint id allocator: keeps its own in-use bitmap and
// range registers, predicts each result and compares it with the output channel
// depends on epid_pkg
`timescale 1ns / 1ps

module endpoint_id_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  epid_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  epid_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata,
	output int                  mismatches,
	output int                  pending_results
);

	import epid_pkg::*;

	// one bit per id, set while the id is handed out
	bit [65535:0]        ids_in_use;
	logic [ID_W-1:0]     range_first_q;
	logic [ID_W-1:0]     range_end_q;
	out_item_t           awaited_results[$];
	int                  fail_count;
	out_item_t           oldest;

	// apply one request to the bitmap and return the answer it gets
	function automatic out_item_t serve_id_request(input in_item_t req);
		out_item_t   res;
		int unsigned lo;
		int unsigned hi;
		res.status     = ST_NOT_IN_USE;
		res.granted_id = '0;
		if (req.operation == OP_ALLOC) begin
			lo = (range_end_q == '0) ? DEFAULT_FIRST : range_first_q;
			hi = (range_end_q == '0) ? DEFAULT_END : range_end_q;
			res.status = ST_EXHAUSTED;
			// lowest free id wins; an empty range falls straight through
			for (int unsigned id = lo; id < hi; id++) begin
				if (!ids_in_use[id]) begin
					ids_in_use[id] = 1'b1;
					res.status     = ST_GRANTED;
					res.granted_id = ID_W'(id);
					break;
				end
			end
		end else if (ids_in_use[req.release_id]) begin
			ids_in_use[req.release_id] = 1'b0;
			res.status = ST_RELEASED;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			ids_in_use      = '0;
			range_first_q   = '0;
			range_end_q     = '0;
			fail_count      = 0;
			mismatches      <= 0;
			pending_results <= 0;
		end else begin
			// result transfer, matched against the oldest prediction
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("status: expected no result, actual %0d (granted_id %0d)",
						out_data.status, out_data.granted_id);
					fail_count++;
				end else begin
					oldest = awaited_results.pop_front();
					if (out_data.status !== oldest.status) begin
						$error("status: expected %0d, actual %0d",
							oldest.status, out_data.status);
						fail_count++;
					end
					if (out_data.granted_id !== oldest.granted_id) begin
						$error("granted_id: expected %0d, actual %0d",
							oldest.granted_id, out_data.granted_id);
						fail_count++;
					end
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_FIRST: range_first_q = cfg_wdata;
					CFG_RANGE_END:   range_end_q   = cfg_wdata;
					default: ;
				endcase
			end

			// request transfer
			if (in_valid && in_ready)
				awaited_results.push_back(serve_id_request(in_data));

			mismatches      <= fail_count;
			pending_results <= awaited_results.size();
		end
	end

endmodule

// File: tb/tb_endpoint_id_allocator_top.sv
// testbench top for the endpoint id allocator: clock, reset, register writes,
// directed and random requests with random idling on both channels, verdict
// depends on epid_pkg, endpoint_id_allocator_top and endpoint_id_checker
`timescale 1ns / 1ps

module tb_endpoint_id_allocator_top;

	import epid_pkg::*;

	localparam int CYCLE_LIMIT  = 2500000;
	localparam int DRAIN_CYCLES = 2100;
	localparam int PHASE_ITEMS  = 58;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	in_item_t        in_data;
	logic            out_valid;
	logic            out_ready;
	out_item_t       out_data;
	logic            cfg_we;
	logic            cfg_index;
	logic [15:0]     cfg_wdata;
	int              mismatches;
	int              pending_results;

	bit              quiet_tail;
	logic [ID_W-1:0] active_first;
	logic [ID_W-1:0] active_end;
	int              cycle_count;

	endpoint_id_allocator_top #(
		.MAP_WORDS(2048),
		.WORD_BITS(32)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	endpoint_id_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.pending_results (pending_results)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin: watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: stall bursts and ready stretches, always ready in the tail
	initial begin: result_sink
		int span;
		bit stall;
		forever begin
			if (quiet_tail) begin
				stall = 1'b0;
				span  = 1;
			end else begin
				stall = ($urandom_range(0, 2) == 0);
				span  = stall ? $urandom_range(1, 13) : $urandom_range(1, 30);
			end
			out_ready <= !stall;
			repeat (span) @(posedge clk);
		end
	end

	// one request transfer, with an optional idle burst ahead of it
	task automatic push_request(input logic op, input logic [ID_W-1:0] id);
		in_item_t item;
		int       gap;
		gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.operation  = op;
		item.release_id = id;
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// let every result come back, then write both range registers
	task automatic set_range(input logic [ID_W-1:0] first, input logic [ID_W-1:0] last);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RANGE_FIRST;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= CFG_RANGE_END;
		cfg_wdata <= last;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_first = first;
		active_end   = last;
	endtask

	// releases mostly aim at the bottom of the range, where grants pile up
	function automatic logic [ID_W-1:0] pick_release_id();
		logic [ID_W-1:0] base;
		base = (active_end == '0) ? DEFAULT_FIRST : active_first;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return base + ID_W'($urandom_range(0, 47));
			6, 7, 8:          return ID_W'($urandom);
			default:          return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	task automatic run_random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 55)
				push_request(OP_ALLOC, ID_W'($urandom));
			else
				push_request(OP_RELEASE, pick_release_id());
		end
	endtask

	initial begin: stimulus
		logic [ID_W-1:0] lo;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_RANGE_FIRST;
		cfg_wdata  <= '0;
		quiet_tail   = 1'b0;
		active_first = '0;
		active_end   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default range: grants from 1, double release, ids outside the range
		push_request(OP_ALLOC, 16'hFFFF);
		push_request(OP_ALLOC, 16'h0000);
		push_request(OP_ALLOC, 16'h5A5A);
		push_request(OP_RELEASE, 16'd2);
		push_request(OP_RELEASE, 16'd2);
		push_request(OP_ALLOC, 16'hA5A5);
		push_request(OP_RELEASE, 16'd0);
		push_request(OP_RELEASE, 16'hFFFF);
		push_request(OP_RELEASE, 16'hFFFE);

		// range from zero: id zero granted, released and granted again
		set_range(16'd0, 16'd3);
		push_request(OP_ALLOC, 16'd0);
		push_request(OP_ALLOC, 16'd0);
		push_request(OP_RELEASE, 16'd0);
		push_request(OP_ALLOC, 16'd0);

		// top of the id space
		set_range(16'hFFFE, 16'hFFFF);
		push_request(OP_ALLOC, 16'd0);
		push_request(OP_ALLOC, 16'd0);
		push_request(OP_RELEASE, 16'hFFFE);
		push_request(OP_RELEASE, 16'hFFFF);

		// empty ranges
		set_range(16'hFFFF, 16'hFFFF);
		push_request(OP_ALLOC, 16'd0);
		set_range(16'hFFFF, 16'd1);
		push_request(OP_ALLOC, 16'd0);
		push_request(OP_RELEASE, 16'd3);

		// random phases over several range settings
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_range(ID_W'($urandom), 16'h0000);
				1: begin
					lo = ID_W'($urandom_range(0, 300));
					set_range(lo, lo + ID_W'($urandom_range(1, 24)));
				end
				2: set_range(ID_W'($urandom_range(65400, 65534)), 16'hFFFF);
				3: set_range(ID_W'($urandom), ID_W'($urandom));
				default: begin
					quiet_tail = 1'b1;
					set_range(16'd0, ID_W'($urandom_range(2, 40)));
				end
			endcase
			run_random_phase(PHASE_ITEMS);
		end

		// wait out every result, then watch for strays
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
